@@ design/reducible_twister_64_generator_assert.svh @@
// Assertion macros shared by the checker of reducible_twister_64_generator.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef REDUCIBLE_TWISTER_64_GENERATOR_ASSERT_SVH
`define REDUCIBLE_TWISTER_64_GENERATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define RTG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define RTG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// same-cycle implication, checked through reset as well
`define RTG_ASSERT_RST(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ design/rtg_pkg.sv @@
// Package of the reducible twister generator: field widths, command and
// register codes, tempering constants. No dependencies.
package rtg_pkg;

	localparam int WORD_W     = 64;
	localparam int CMD_W      = 2;
	localparam int SEED_IDX_W = 9;
	localparam int WC_W       = 10;
	localparam int OFF_W      = 9;
	localparam int CFG_IDX_W  = 3;

	localparam int MAX_WORDS_DEF = 512;
	localparam int WC_RESET      = 312;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_SEAL = 2'd1,
		CMD_GEN  = 2'd2
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TWIST_MATRIX  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPER_MASK_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPER_MASK_C = 3'd4;

	localparam int MIX_SHIFT = 17;
	localparam int TEMPER_U  = 29;
	localparam int TEMPER_S  = 17;
	localparam int TEMPER_T  = 37;
	localparam int TEMPER_L  = 43;
	localparam logic [WORD_W-1:0] TEMPER_MASK_A = 64'h5555555555555555;

endpackage

@@ design/rtg_mod.sv @@
// Bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle.
// Depends on rtg_pkg for default widths.
module rtg_mod #(
	parameter int DVW = rtg_pkg::OFF_W,
	parameter int NW  = $clog2(rtg_pkg::MAX_WORDS_DEF + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DVW-1:0] dividend,
	input  logic [NW-1:0]  divisor,
	output logic           done,
	output logic [NW-1:0]  remainder
);

	localparam int CTW = $clog2(DVW + 1);

	logic           busy_q;
	logic           done_q;
	logic [CTW-1:0] cnt_q;
	logic [DVW-1:0] dvd_q;
	logic [NW-1:0]  dsr_q;
	logic [NW-1:0]  rem_q;

	logic [NW:0]    trial;
	logic [NW:0]    dsr_ext;
	logic [NW-1:0]  rem_next;

	assign trial    = {rem_q, dvd_q[DVW-1]};
	assign dsr_ext  = {1'b0, dsr_q};
	assign rem_next = (trial >= dsr_ext) ? NW'(trial - dsr_ext) : trial[NW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CTW'(DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CTW'(1);
				if (cnt_q == CTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ design/reducible_twister_64_generator.sv @@
// Top level of the 64-bit reducible twister generator.
// Depends on rtg_pkg and rtg_mod.

// A command (load seed word, seal seed, generate) is taken on every clock in
// which item_valid is high and item_stall is low; the sustained rate is one
// command per cycle while item_stall stays low, and a generate result passes
// the issue stage and the write-back stage into the result register. The ring
// lives in a word memory with two registered read ports and one write port:
// the issue stage reads the word at the new position and the word offset
// places on, the next stage mixes, writes back and tempers, and a write in
// that stage is forwarded into a read issued on the same edge. Nonzero flags
// sit in a second one-bit memory with a running count, so a seal never walks
// the ring. After reset a clearing pass zeroes the flag memory with item_stall
// held high (configuration writes are taken meanwhile). The first generate
// after a word_count or offset write may run the bit-serial remainder unit up
// to three times to reduce the offset and the position modulo the ring length.
module reducible_twister_64_generator #(
	parameter int MAX_WORDS = rtg_pkg::MAX_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_write,
	input  logic [rtg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtg_pkg::WORD_W-1:0]      cfg_data,
	// command channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [rtg_pkg::CMD_W-1:0]       command,
	input  logic [rtg_pkg::SEED_IDX_W-1:0]  seed_index,
	input  logic [rtg_pkg::WORD_W-1:0]      seed_value,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [rtg_pkg::WORD_W-1:0]      random_word
);

	localparam int WW  = rtg_pkg::WORD_W;
	localparam int AW  = $clog2(MAX_WORDS);         // ring index
	localparam int NW  = $clog2(MAX_WORDS + 1);     // ring length, flag count
	localparam int SW  = AW + 1;                    // index sums
	localparam int CW  = (NW > rtg_pkg::WC_W) ? NW : rtg_pkg::WC_W;
	localparam int LW  = (NW > rtg_pkg::SEED_IDX_W) ? NW : rtg_pkg::SEED_IDX_W;
	localparam int DVW = (AW > rtg_pkg::OFF_W) ? AW : rtg_pkg::OFF_W;
	localparam int RESET_N = (rtg_pkg::WC_RESET > MAX_WORDS) ? MAX_WORDS : rtg_pkg::WC_RESET;

	// sequencer: clearing pass, running, or one of three remainder runs
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_RED   = 5'b00100,   // offset mod length at its write
		ST_CUR   = 5'b01000,   // stored offset mod current length
		ST_POS   = 5'b10000    // position mod current length
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;

	// configuration
	logic [rtg_pkg::WC_W-1:0]  word_count_q;
	logic [rtg_pkg::OFF_W-1:0] offset_raw_q;
	logic [NW-1:0]             offset_n_q;     // ring length when offset was written
	logic [AW-1:0]             offset_red_q;   // offset as the ring saw it then
	logic                      red_ok_q;
	logic [AW-1:0]             off_cur_q;      // offset reduced by the current length
	logic                      cur_ok_q;
	logic [WW-1:0]             twist_q;
	logic [WW-1:0]             mask_b_q;
	logic [WW-1:0]             mask_c_q;

	// ring state
	logic [AW-1:0] pos_q;
	logic [NW-1:0] nz_count_q;
	logic [WW-1:0] word_mem [MAX_WORDS];
	logic          flag_mem [MAX_WORDS];

	// issue stage
	logic                          s1_valid_s1;
	logic [rtg_pkg::CMD_W-1:0]     s1_cmd_s1;
	logic [rtg_pkg::SEED_IDX_W-1:0] s1_idx_s1;
	logic [WW-1:0]                 s1_value_s1;

	// read / write-back stage
	logic                      s2_valid_s2;
	logic [rtg_pkg::CMD_W-1:0] s2_cmd_s2;
	logic [AW-1:0]             s2_addr_s2;
	logic [WW-1:0]             s2_value_s2;
	logic                      s2_load_ok_s2;
	logic [WW-1:0]             x_rd_s2;
	logic [WW-1:0]             y_rd_s2;
	logic                      flag_rd_s2;
	logic                      fwd_x_s2;
	logic                      fwd_y_s2;
	logic                      fwd_f_s2;
	logic [WW-1:0]             fwd_wd_s2;
	logic                      fwd_nz_s2;

	// result register
	logic          result_valid_q;
	logic [WW-1:0] random_word_q;

	// remainder unit
	logic           mod_start;
	logic [DVW-1:0] mod_dvd;
	logic [NW-1:0]  mod_dsr;
	logic           mod_done;
	logic [NW-1:0]  mod_rem;

	// ---------------------------------------------------------------
	// ring length: 0 counts as 1, anything above MAX_WORDS as MAX_WORDS
	// ---------------------------------------------------------------
	logic [CW-1:0] wc_ext;
	logic [NW-1:0] ring_n;

	assign wc_ext = CW'(word_count_q);
	always_comb begin
		if (word_count_q == '0) begin
			ring_n = NW'(1);
		end else if (wc_ext > CW'(MAX_WORDS)) begin
			ring_n = NW'(MAX_WORDS);
		end else begin
			ring_n = wc_ext[NW-1:0];
		end
	end

	// ---------------------------------------------------------------
	// issue stage: addresses, preparation check, handshake
	// ---------------------------------------------------------------
	logic          s1_gen;
	logic          need_red, need_cur, need_pos, need_any;
	logic [SW-1:0] n_ext;
	logic [SW-1:0] psum;
	logic [AW-1:0] p_next;
	logic [SW-1:0] ysum;
	logic [SW-1:0] ywrap;
	logic [AW-1:0] y_idx;
	logic          load_ok;
	logic [AW-1:0] s1_waddr;
	logic          s1_go, s2_go, s2_free, out_free, item_xfer;

	assign s1_gen   = (s1_cmd_s1 == rtg_pkg::CMD_GEN);
	assign n_ext    = SW'(ring_n);
	assign need_red = !red_ok_q;
	assign need_cur = !cur_ok_q;
	assign need_pos = (SW'(pos_q) >= n_ext);   // ring shrank under the position
	assign need_any = need_red || need_cur || need_pos;

	// with the position below the length, the step is a wrap on equality
	assign psum   = SW'(pos_q) + SW'(1);
	assign p_next = (psum == n_ext) ? '0 : psum[AW-1:0];
	// both terms below the length: one conditional subtract
	assign ysum   = SW'(p_next) + SW'(off_cur_q);
	assign ywrap  = (ysum >= n_ext) ? (ysum - n_ext) : ysum;
	assign y_idx  = ywrap[AW-1:0];

	assign load_ok = (LW'(s1_idx_s1) < LW'(ring_n));

	always_comb begin
		case (s1_cmd_s1)
			rtg_pkg::CMD_GEN:  s1_waddr = p_next;
			rtg_pkg::CMD_LOAD: s1_waddr = AW'(s1_idx_s1);
			default:           s1_waddr = '0;   // seal touches word 0
		endcase
	end

	assign out_free   = !result_valid_q || !result_stall;
	assign s2_go      = s2_valid_s2 && ((s2_cmd_s2 != rtg_pkg::CMD_GEN) || out_free);
	assign s2_free    = !s2_valid_s2 || s2_go;
	assign s1_go      = s1_valid_s1 && (state_q == ST_RUN) && !(s1_gen && need_any) && s2_free;
	assign item_stall = (state_q == ST_CLEAR) || (s1_valid_s1 && !s1_go);
	assign item_xfer  = item_valid && !item_stall;

	// ---------------------------------------------------------------
	// remainder unit requests, in priority order
	// ---------------------------------------------------------------
	assign mod_start = (state_q == ST_RUN) && s1_valid_s1 && s1_gen && need_any;

	always_comb begin
		if (need_red) begin
			mod_dvd = DVW'(offset_raw_q);
			mod_dsr = offset_n_q;
		end else if (need_cur) begin
			mod_dvd = DVW'(offset_red_q);
			mod_dsr = ring_n;
		end else begin
			mod_dvd = DVW'(pos_q);
			mod_dsr = ring_n;
		end
	end

	rtg_mod #(
		.DVW(DVW),
		.NW (NW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (mod_dsr),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	// ---------------------------------------------------------------
	// write-back stage: forwarding, mix, flag count, tempering
	// ---------------------------------------------------------------
	logic          s2_gen;
	logic [WW-1:0] xr, yr, ym, xn;
	logic [WW-1:0] t1, t2, t3, t4;
	logic          s2_we;
	logic [WW-1:0] s2_wd;
	logic          old_flag;
	logic          new_flag;

	assign s2_gen = (s2_cmd_s2 == rtg_pkg::CMD_GEN);
	assign xr     = fwd_x_s2 ? fwd_wd_s2 : x_rd_s2;
	assign yr     = fwd_y_s2 ? fwd_wd_s2 : y_rd_s2;
	assign old_flag = fwd_f_s2 ? fwd_nz_s2 : flag_rd_s2;

	assign ym = yr ^ (yr << rtg_pkg::MIX_SHIFT);
	assign xn = ym ^ (xr >> 1) ^ (xr[0] ? twist_q : '0);

	assign t1 = xn ^ ((xn >> rtg_pkg::TEMPER_U) & rtg_pkg::TEMPER_MASK_A);
	assign t2 = t1 ^ ((t1 << rtg_pkg::TEMPER_S) & mask_b_q);
	assign t3 = t2 ^ ((t2 << rtg_pkg::TEMPER_T) & mask_c_q);
	assign t4 = t3 ^ (t3 >> rtg_pkg::TEMPER_L);

	always_comb begin
		case (s2_cmd_s2)
			rtg_pkg::CMD_GEN: begin
				s2_we = 1'b1;
				s2_wd = xn;
			end
			rtg_pkg::CMD_LOAD: begin
				s2_we = s2_load_ok_s2;
				s2_wd = s2_value_s2;
			end
			rtg_pkg::CMD_SEAL: begin
				// all flags clear: force word 0 to one
				s2_we = (nz_count_q == '0);
				s2_wd = WW'(1);
			end
			default: begin
				s2_we = 1'b0;
				s2_wd = s2_value_s2;
			end
		endcase
	end

	assign new_flag = (s2_wd != '0);

	// ---------------------------------------------------------------
	// memories
	// ---------------------------------------------------------------
	logic          wr_en;
	logic          flag_we;
	logic [AW-1:0] flag_wa;
	logic          flag_wd;

	assign wr_en   = s2_go && s2_we;
	assign flag_we = (state_q == ST_CLEAR) || wr_en;
	assign flag_wa = (state_q == ST_CLEAR) ? clr_q : s2_addr_s2;
	assign flag_wd = (state_q == ST_CLEAR) ? 1'b0 : new_flag;

	// reads return the old word on a same-address write; forwarding covers it
	always_ff @(posedge clk) begin
		if (s1_go) begin
			x_rd_s2 <= word_mem[p_next];
			y_rd_s2 <= word_mem[y_idx];
		end
		if (wr_en) begin
			word_mem[s2_addr_s2] <= s2_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			flag_rd_s2 <= flag_mem[s1_waddr];
		end
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_WORDS - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (mod_start) begin
						if (need_red) begin
							state_q <= ST_RED;
						end else if (need_cur) begin
							state_q <= ST_CUR;
						end else begin
							state_q <= ST_POS;
						end
					end
				end
				ST_RED, ST_CUR, ST_POS: begin
					if (mod_done) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// configuration, offset reductions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= rtg_pkg::WC_W'(rtg_pkg::WC_RESET);
			offset_raw_q <= '0;
			offset_n_q   <= NW'(RESET_N);
			offset_red_q <= '0;
			red_ok_q     <= 1'b1;
			off_cur_q    <= '0;
			cur_ok_q     <= 1'b1;
			twist_q      <= '0;
			mask_b_q     <= '0;
			mask_c_q     <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					rtg_pkg::REG_WORD_COUNT: begin
						word_count_q <= cfg_data[rtg_pkg::WC_W-1:0];
						cur_ok_q     <= 1'b0;
					end
					rtg_pkg::REG_OFFSET: begin
						offset_raw_q <= cfg_data[rtg_pkg::OFF_W-1:0];
						offset_n_q   <= ring_n;
						red_ok_q     <= 1'b0;
						cur_ok_q     <= 1'b0;
					end
					rtg_pkg::REG_TWIST_MATRIX:  twist_q  <= cfg_data;
					rtg_pkg::REG_TEMPER_MASK_B: mask_b_q <= cfg_data;
					rtg_pkg::REG_TEMPER_MASK_C: mask_c_q <= cfg_data;
					default: ;
				endcase
			end
			if (mod_done && (state_q == ST_RED)) begin
				offset_red_q <= AW'(mod_rem);
				red_ok_q     <= 1'b1;
			end
			if (mod_done && (state_q == ST_CUR)) begin
				off_cur_q <= AW'(mod_rem);
				cur_ok_q  <= 1'b1;
			end
		end
	end

	// pipeline valids, position, flag count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1    <= 1'b0;
			s2_valid_s2    <= 1'b0;
			result_valid_q <= 1'b0;
			pos_q          <= AW'(RESET_N - 1);
			nz_count_q     <= '0;
		end else begin
			if (item_xfer) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_go) begin
				s1_valid_s1 <= 1'b0;
			end

			if (s1_go) begin
				s2_valid_s2 <= 1'b1;
			end else if (s2_go) begin
				s2_valid_s2 <= 1'b0;
			end

			if (s2_go && s2_gen) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			if (s1_go && s1_gen) begin
				pos_q <= p_next;
			end else if (s1_go && (s1_cmd_s1 == rtg_pkg::CMD_SEAL)) begin
				pos_q <= AW'(ring_n - NW'(1));
			end else if (mod_done && (state_q == ST_POS)) begin
				// same residue, so the step that follows is unchanged
				pos_q <= AW'(mod_rem);
			end

			if (wr_en) begin
				if (new_flag && !old_flag) begin
					nz_count_q <= nz_count_q + NW'(1);
				end else if (!new_flag && old_flag) begin
					nz_count_q <= nz_count_q - NW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			s1_cmd_s1   <= command;
			s1_idx_s1   <= seed_index;
			s1_value_s1 <= seed_value;
		end
		if (s1_go) begin
			s2_cmd_s2     <= s1_cmd_s1;
			s2_addr_s2    <= s1_waddr;
			s2_value_s2   <= s1_value_s1;
			s2_load_ok_s2 <= load_ok;
			// write-back landing on the same edge as these reads
			fwd_x_s2  <= wr_en && (s2_addr_s2 == p_next);
			fwd_y_s2  <= wr_en && (s2_addr_s2 == y_idx);
			fwd_f_s2  <= wr_en && (s2_addr_s2 == s1_waddr);
			fwd_wd_s2 <= s2_wd;
			fwd_nz_s2 <= new_flag;
		end
		if (s2_go && s2_gen) begin
			random_word_q <= t4;
		end
	end

	assign result_valid = result_valid_q;
	assign random_word  = random_word_q;

endmodule

@@ design/rtg_checker.sv @@
// Port-level checker for reducible_twister_64_generator, bound to the top.
// Depends on rtg_pkg and reducible_twister_64_generator_assert.svh.
`include "reducible_twister_64_generator_assert.svh"

module rtg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_stall,
	input logic [rtg_pkg::CMD_W-1:0]      command,
	input logic                           result_valid,
	input logic                           result_stall,
	input logic [rtg_pkg::WORD_W-1:0]     random_word
);

	// generates accepted but not yet delivered
	logic [2:0] pend_q;
	logic       gen_xfer;
	logic       res_xfer;

	assign gen_xfer = item_valid && !item_stall && (command == rtg_pkg::CMD_GEN);
	assign res_xfer = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (gen_xfer && !res_xfer) begin
			pend_q <= pend_q + 3'd1;
		end else if (!gen_xfer && res_xfer) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	`RTG_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(random_word), "stalled result changed")
	`RTG_ASSERT_IMP(a_no_extra_result, res_xfer, pend_q != 3'd0, "result without a pending generate")
	`RTG_ASSERT_IMP(a_depth, 1'b1, pend_q <= 3'd3, "more generates in flight than stages")
	`RTG_ASSERT_RST(a_clear_stall, $rose(arst_n), item_stall, "command taken during clearing pass")

endmodule

bind reducible_twister_64_generator rtg_checker u_rtg_checker (.*);
